/* design/mbet_pkg.sv */
// Shared types and constants for the escape-time pixel block.
// Used by mbet_mul, mbet_div and mandelbrot_escape_time_pixel.
package mbet_pkg;

    typedef enum logic [1:0] {
        SH_FRAC,
        SH_ONE,
        SH_COLOR,
        SH_RECIP
    } t_mul_shift;

    typedef struct packed {
        logic       start;
        logic       neg;
        t_mul_shift sh;
        logic [63:0] a;
        logic [63:0] b;
    } t_mul_req;

    typedef enum logic [4:0] {
        ST_IDLE,
        ST_CX,
        ST_CX_W,
        ST_CY,
        ST_CY_W,
        ST_SX,
        ST_SX_W,
        ST_SY,
        ST_SY_W,
        ST_P,
        ST_P_W,
        ST_ADIV,
        ST_ADIV_W,
        ST_RED,
        ST_FOLD,
        ST_X2,
        ST_X2_W,
        ST_CDIV,
        ST_CDIV_W,
        ST_AMUL,
        ST_AMUL_W,
        ST_SIN,
        ST_SIN_W,
        ST_DONE
    } t_state;

    localparam logic [2:0] CFG_CENTER_REAL = 3'd0;
    localparam logic [2:0] CFG_CENTER_IMAG = 3'd1;
    localparam logic [2:0] CFG_PIXEL_STEP  = 3'd2;
    localparam logic [2:0] CFG_IMAGE_SIZE  = 3'd3;
    localparam logic [2:0] CFG_MAX_ITER    = 3'd4;

    localparam logic [63:0] PI_Q60 = 64'h3243F6A8885A308D;

    localparam logic [15:0] SINE_DIV [4] = '{16'd72, 16'd42, 16'd20, 16'd6};

endpackage

/* design/mbet_mul.sv */
// Shared magnitude multiplier: 64x64 product from four 32x32 partial products,
// then shift, saturate and sign. Depends on mbet_pkg.
module mbet_mul import mbet_pkg::*; #(
    parameter int WORD_WIDTH      = 64,
    parameter int FRAC_BITS       = 56,
    parameter int COLOR_FRAC_BITS = 16
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  t_mul_req              i_req,
    output logic                  o_done,
    output logic [WORD_WIDTH-1:0] o_res
);

    localparam logic [63:0] WMAX_U = 64'((65'd1 << (WORD_WIDTH - 1)) - 65'd1);

    logic                  r_busy;
    logic                  r_done;
    logic [2:0]            r_cnt;
    logic [63:0]           r_a;
    logic [63:0]           r_b;
    logic                  r_neg;
    t_mul_shift            r_sh;
    logic [63:0]           r_prod;
    logic [1:0]            r_off;
    logic [127:0]          r_acc;
    logic [WORD_WIDTH-1:0] r_res;

    logic [31:0]           a_half;
    logic [31:0]           b_half;
    logic [127:0]          shifted;
    logic [127:0]          lim;
    logic [127:0]          sat;
    logic [WORD_WIDTH-1:0] fin;

    always_comb begin
        a_half = r_cnt[0] ? r_a[63:32] : r_a[31:0];
        b_half = r_cnt[1] ? r_b[63:32] : r_b[31:0];
        case (r_sh)
            SH_FRAC:  shifted = r_acc >> FRAC_BITS;
            SH_ONE:   shifted = r_acc >> 1;
            SH_COLOR: shifted = r_acc >> COLOR_FRAC_BITS;
            SH_RECIP: shifted = r_acc >> (COLOR_FRAC_BITS + 9);
            default:  shifted = r_acc;
        endcase
        lim = r_neg ? 128'(WMAX_U) + 128'd1 : 128'(WMAX_U);
        sat = (shifted > lim) ? lim : shifted;
        fin = r_neg ? -sat[WORD_WIDTH-1:0] : sat[WORD_WIDTH-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= 3'd0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_busy <= 1'b1;
                r_cnt  <= 3'd0;
                r_acc  <= '0;
                r_a    <= i_req.a;
                r_b    <= i_req.b;
                r_neg  <= i_req.neg;
                r_sh   <= i_req.sh;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 3'd1;
                if (r_cnt < 3'd4) begin
                    r_prod <= 64'(a_half) * 64'(b_half);
                    r_off  <= {1'b0, r_cnt[0]} + {1'b0, r_cnt[1]};
                end
                if (r_cnt >= 3'd1 && r_cnt <= 3'd4) begin
                    r_acc <= r_acc + (128'(r_prod) << {r_off, 5'b0});
                end
                if (r_cnt == 3'd5) begin
                    r_res  <= fin;
                    r_done <= 1'b1;
                    r_busy <= 1'b0;
                end
            end
        end
    end

    assign o_done = r_done;
    assign o_res  = r_res;

endmodule

/* design/mbet_div.sv */
// Restoring divider, one quotient bit per cycle, for a left-aligned numerator.
// Depends on mbet_pkg.
module mbet_div import mbet_pkg::*; #(
    parameter int NUM_WIDTH = 36
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_start,
    input  logic [NUM_WIDTH-1:0]         i_num,
    input  logic [15:0]                  i_den,
    input  logic [$clog2(NUM_WIDTH+1)-1:0] i_bits,
    output logic                         o_done,
    output logic [NUM_WIDTH-1:0]         o_quot
);

    localparam int CW = $clog2(NUM_WIDTH + 1);

    logic                 r_busy;
    logic                 r_done;
    logic [CW-1:0]        r_cnt;
    logic [NUM_WIDTH-1:0] r_num;
    logic [NUM_WIDTH-1:0] r_quo;
    logic [15:0]          r_rem;
    logic [15:0]          r_den;

    logic [16:0] trial;
    logic        ge;

    always_comb begin
        trial = {r_rem, r_num[NUM_WIDTH-1]};
        ge    = trial >= {1'b0, r_den};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= i_bits;
                r_num  <= i_num;
                r_quo  <= '0;
                r_rem  <= '0;
                r_den  <= i_den;
            end else if (r_busy) begin
                r_rem <= ge ? 16'(trial - {1'b0, r_den}) : trial[15:0];
                r_num <= r_num << 1;
                r_quo <= {r_quo[NUM_WIDTH-2:0], ge};
                r_cnt <= r_cnt - CW'(1);
                if (r_cnt == CW'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_done = r_done;
    assign o_quot = r_quo;

endmodule

/* design/mandelbrot_escape_time_pixel.sv */
// Escape-time pixel evaluator: sequencer around the shared multiplier and divider.
// Depends on mbet_pkg, mbet_mul and mbet_div.
//
// Usage:
//   Input channel i_in_valid/o_in_ready carries one pixel word (x, y). Output
//   channel o_out_valid/i_out_ready carries the iteration count and ARGB word.
//   Configuration is written through i_cfg_we/i_cfg_index/i_cfg_data; the user
//   must write it only while idle, as the block itself does not enforce this.
//   One pixel is in work at a time; o_in_ready is high only when idle.
//   Every multiply runs on the shared 32x32 multiplier (four partial products,
//   accumulate, saturate), and each iteration takes three multiplies. An
//   escaping point then needs one division on the serial divider, then per
//   channel nine multiplies (five for the series, four reciprocal multiplies
//   for the constant divisions). Points that hit the limit skip colour.
//   The result sits in an output register; a stalled receiver holds it, and
//   the block may take and compute the next pixel meanwhile, waiting at the
//   end until the register frees.
//   Reset clears the control state and loads the default view registers.
module mandelbrot_escape_time_pixel import mbet_pkg::*; #(
    parameter int WORD_WIDTH      = 64,
    parameter int FRAC_BITS       = 56,
    parameter int COLOR_FRAC_BITS = 16
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  logic [11:0] i_pixel_x,
    input  logic [11:0] i_pixel_y,
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic [15:0] o_iteration_count,
    output logic [31:0] o_pixel_argb,
    input  logic        i_cfg_we,
    input  logic [2:0]  i_cfg_index,
    input  logic [63:0] i_cfg_data
);

    localparam int W   = WORD_WIDTH;
    localparam int CF  = COLOR_FRAC_BITS;
    localparam int XW  = CF + 4;
    localparam int ND  = CF + 20;
    localparam int BW  = $clog2(ND + 1);
    localparam int VW  = CF + 10;

    localparam logic [63:0]  WMAX_U = 64'((65'd1 << (W - 1)) - 65'd1);
    localparam logic [W-1:0] WMAX_W = WMAX_U[W-1:0];
    localparam logic [W-1:0] WMIN_W = ~WMAX_W;
    localparam logic [63:0]  FOUR_F = 64'd4 << FRAC_BITS;
    localparam logic [63:0]  FOUR_U = (FOUR_F > WMAX_U) ? WMAX_U : FOUR_F;
    localparam logic [W-1:0] FOUR_W = FOUR_U[W-1:0];

    localparam logic [XW-1:0] PI_X     = XW'(PI_Q60 >> (60 - CF));
    localparam logic [XW-1:0] HALF_X   = XW'(PI_Q60 >> (61 - CF));
    localparam logic [XW-1:0] TWO_PI_X = XW'(PI_Q60 >> (59 - CF));
    localparam logic [CF+1:0] ONE_C    = (CF+2)'(1) << CF;
    localparam logic [VW-1:0] BASE_V   = VW'(127) << CF;

    localparam logic [63:0] RECIP_ONE = 64'd1 << (CF + 9);
    localparam logic [63:0] SINE_RECIP [4] = '{
        (RECIP_ONE + 64'(SINE_DIV[0]) - 64'd1) / 64'(SINE_DIV[0]),
        (RECIP_ONE + 64'(SINE_DIV[1]) - 64'd1) / 64'(SINE_DIV[1]),
        (RECIP_ONE + 64'(SINE_DIV[2]) - 64'd1) / 64'(SINE_DIV[2]),
        (RECIP_ONE + 64'(SINE_DIV[3]) - 64'd1) / 64'(SINE_DIV[3])
    };

    function automatic logic [W-1:0] sat_add(input logic [W-1:0] a, input logic [W-1:0] b);
        logic [W:0] s;
        s = {a[W-1], a} + {b[W-1], b};
        if (s[W] != s[W-1]) return s[W] ? WMIN_W : WMAX_W;
        return s[W-1:0];
    endfunction

    function automatic logic [W-1:0] sat_sub(input logic [W-1:0] a, input logic [W-1:0] b);
        logic [W:0] s;
        s = {a[W-1], a} - {b[W-1], b};
        if (s[W] != s[W-1]) return s[W] ? WMIN_W : WMAX_W;
        return s[W-1:0];
    endfunction

    function automatic logic [W-1:0] mag_w(input logic [W-1:0] v);
        return v[W-1] ? -v : v;
    endfunction

    function automatic logic [W-1:0] clamp_c(input logic [63:0] c);
        if ($signed(c) > $signed(WMAX_U)) return WMAX_W;
        if ($signed(c) < $signed(~WMAX_U)) return WMIN_W;
        return c[W-1:0];
    endfunction

    function automatic logic [7:0] chan(input logic [CF:0] s, input logic neg);
        logic [VW-1:0] m;
        logic [VW-1:0] v;
        logic [8:0]    c;
        m = VW'(s) << 7;
        v = neg ? BASE_V - m : BASE_V + m;
        c = v[VW-2:CF];
        if (v[VW-1]) return 8'd0;
        if (c > 9'd255) return 8'd255;
        return c[7:0];
    endfunction

    // configuration
    logic [63:0] r_center_real;
    logic [63:0] r_center_imag;
    logic [62:0] r_step;
    logic [12:0] r_size;
    logic [15:0] r_max;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_center_real <= 64'hFF80000000000000;
            r_center_imag <= 64'd0;
            r_step        <= 63'd422212465065984;
            r_size        <= 13'd512;
            r_max         <= 16'd50;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_CENTER_REAL: r_center_real <= i_cfg_data;
                CFG_CENTER_IMAG: r_center_imag <= i_cfg_data;
                CFG_PIXEL_STEP:  r_step        <= i_cfg_data[62:0];
                CFG_IMAGE_SIZE:  r_size        <= i_cfg_data[12:0];
                CFG_MAX_ITER:    r_max         <= i_cfg_data[15:0];
                default: ;
            endcase
        end
    end

    t_state r_state, n_state;
    logic [11:0]   r_px, n_px, r_py, n_py;
    logic [W-1:0]  r_cx, n_cx, r_cy, n_cy;
    logic [W-1:0]  r_zx, n_zx, r_zy, n_zy;
    logic [W-1:0]  r_sx, n_sx, r_sy, n_sy;
    logic [15:0]   r_count, n_count;
    logic [XW-1:0] r_q, n_q, r_x, n_x;
    logic [CF+1:0] r_x2, n_x2, r_t, n_t;
    logic [CF:0]   r_a, n_a;
    logic          r_neg, n_neg;
    logic [1:0]    r_phase, n_phase;
    logic [1:0]    r_k, n_k;
    logic [7:0]    r_red, n_red, r_grn, n_grn, r_blu, n_blu;
    logic          r_out_valid, n_out_valid;
    logic [15:0]   r_out_count, n_out_count;
    logic [31:0]   r_out_argb, n_out_argb;

    t_mul_req       mul_req;
    logic           mul_done;
    logic [W-1:0]   mul_res;
    logic           div_start;
    logic [ND-1:0]  div_num;
    logic [15:0]    div_den;
    logic [BW-1:0]  div_bits;
    logic           div_done;
    logic [ND-1:0]  div_quot;

    logic [14:0]   dx, dy;
    logic [13:0]   dmag_x, dmag_y;
    logic [63:0]   step_w;
    logic [19:0]   ten_count;
    logic [XW-1:0] fold1;
    logic [7:0]    ch;

    mbet_mul #(
        .WORD_WIDTH     (WORD_WIDTH),
        .FRAC_BITS      (FRAC_BITS),
        .COLOR_FRAC_BITS(COLOR_FRAC_BITS)
    ) u_mul (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_req  (mul_req),
        .o_done (mul_done),
        .o_res  (mul_res)
    );

    mbet_div #(
        .NUM_WIDTH(ND)
    ) u_div (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_start(div_start),
        .i_num  (div_num),
        .i_den  (div_den),
        .i_bits (div_bits),
        .o_done (div_done),
        .o_quot (div_quot)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_px <= n_px;       r_py <= n_py;
        r_cx <= n_cx;       r_cy <= n_cy;
        r_zx <= n_zx;       r_zy <= n_zy;
        r_sx <= n_sx;       r_sy <= n_sy;
        r_count <= n_count;
        r_q <= n_q;         r_x <= n_x;
        r_x2 <= n_x2;       r_t <= n_t;
        r_a <= n_a;         r_neg <= n_neg;
        r_phase <= n_phase; r_k <= n_k;
        r_red <= n_red;     r_grn <= n_grn;   r_blu <= n_blu;
        r_out_count <= n_out_count;
        r_out_argb  <= n_out_argb;
    end

    always_comb begin
        dx        = {2'b00, r_px, 1'b0} - {2'b00, r_size};
        dy        = {2'b00, r_py, 1'b0} - {2'b00, r_size};
        dmag_x    = dx[14] ? 14'(-dx) : dx[13:0];
        dmag_y    = dy[14] ? 14'(-dy) : dy[13:0];
        step_w    = ({1'b0, r_step} > WMAX_U) ? WMAX_U : {1'b0, r_step};
        ten_count = 20'(r_count) * 20'd10;
        fold1     = (r_x > PI_X) ? r_x - PI_X : r_x;
        ch        = chan(mul_res[CF:0], r_neg);

        n_state = r_state;
        n_px = r_px;   n_py = r_py;
        n_cx = r_cx;   n_cy = r_cy;
        n_zx = r_zx;   n_zy = r_zy;
        n_sx = r_sx;   n_sy = r_sy;
        n_count = r_count;
        n_q = r_q;     n_x = r_x;
        n_x2 = r_x2;   n_t = r_t;
        n_a = r_a;     n_neg = r_neg;
        n_phase = r_phase; n_k = r_k;
        n_red = r_red; n_grn = r_grn; n_blu = r_blu;
        n_out_valid = r_out_valid && !i_out_ready;
        n_out_count = r_out_count;
        n_out_argb  = r_out_argb;

        mul_req.start = 1'b0;
        mul_req.neg   = 1'b0;
        mul_req.sh    = SH_FRAC;
        mul_req.a     = 64'(mag_w(r_zx));
        mul_req.b     = 64'(mag_w(r_zx));
        div_start = 1'b0;
        div_num   = {ten_count, {CF{1'b0}}};
        div_den   = r_max;
        div_bits  = BW'(ND);
        o_in_ready = 1'b0;

        case (r_state)
            ST_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    n_px    = i_pixel_x;
                    n_py    = i_pixel_y;
                    n_state = ST_CX;
                end
            end
            ST_CX: begin
                mul_req.start = 1'b1;
                mul_req.neg   = dx[14];
                mul_req.sh    = SH_ONE;
                mul_req.a     = 64'(dmag_x);
                mul_req.b     = step_w;
                n_state       = ST_CX_W;
            end
            ST_CX_W: begin
                if (mul_done) begin
                    n_cx    = sat_add(clamp_c(r_center_real), mul_res);
                    n_state = ST_CY;
                end
            end
            ST_CY: begin
                mul_req.start = 1'b1;
                mul_req.neg   = dy[14];
                mul_req.sh    = SH_ONE;
                mul_req.a     = 64'(dmag_y);
                mul_req.b     = step_w;
                n_state       = ST_CY_W;
            end
            ST_CY_W: begin
                if (mul_done) begin
                    n_cy    = sat_add(clamp_c(r_center_imag), mul_res);
                    n_zx    = '0;
                    n_zy    = '0;
                    n_count = '0;
                    n_state = ST_SX;
                end
            end
            ST_SX: begin
                if (r_count >= r_max) begin
                    n_red   = 8'd0;
                    n_grn   = 8'd0;
                    n_blu   = 8'd0;
                    n_state = ST_DONE;
                end else begin
                    mul_req.start = 1'b1;
                    n_state       = ST_SX_W;
                end
            end
            ST_SX_W: begin
                if (mul_done) begin
                    n_sx    = mul_res;
                    n_state = ST_SY;
                end
            end
            ST_SY: begin
                mul_req.start = 1'b1;
                mul_req.a     = 64'(mag_w(r_zy));
                mul_req.b     = 64'(mag_w(r_zy));
                n_state       = ST_SY_W;
            end
            ST_SY_W: begin
                if (mul_done) begin
                    n_sy = mul_res;
                    if ($signed(sat_add(r_sx, mul_res)) > $signed(FOUR_W)) begin
                        n_state = ST_ADIV;
                    end else begin
                        n_state = ST_P;
                    end
                end
            end
            ST_P: begin
                mul_req.start = 1'b1;
                mul_req.neg   = r_zx[W-1] ^ r_zy[W-1];
                mul_req.b     = 64'(mag_w(r_zy));
                n_state       = ST_P_W;
            end
            ST_P_W: begin
                if (mul_done) begin
                    n_zx    = sat_add(sat_sub(r_sx, r_sy), r_cx);
                    n_zy    = sat_add(sat_add(mul_res, mul_res), r_cy);
                    n_count = r_count + 16'd1;
                    n_state = ST_SX;
                end
            end
            ST_ADIV: begin
                div_start = 1'b1;
                div_num   = {ten_count, {CF{1'b0}}};
                div_den   = r_max;
                div_bits  = BW'(ND);
                n_state   = ST_ADIV_W;
            end
            ST_ADIV_W: begin
                if (div_done) begin
                    n_q     = div_quot[XW-1:0];
                    n_x     = div_quot[XW-1:0];
                    n_phase = 2'd0;
                    n_state = ST_RED;
                end
            end
            ST_RED: begin
                if (r_x >= TWO_PI_X) begin
                    n_x = r_x - TWO_PI_X;
                end else begin
                    n_state = ST_FOLD;
                end
            end
            ST_FOLD: begin
                n_neg   = r_x > PI_X;
                n_x     = (fold1 > HALF_X) ? PI_X - fold1 : fold1;
                n_state = ST_X2;
            end
            ST_X2: begin
                mul_req.start = 1'b1;
                mul_req.sh    = SH_COLOR;
                mul_req.a     = 64'(r_x);
                mul_req.b     = 64'(r_x);
                n_state       = ST_X2_W;
            end
            ST_X2_W: begin
                if (mul_done) begin
                    n_x2    = mul_res[CF+1:0];
                    n_t     = mul_res[CF+1:0];
                    n_k     = 2'd0;
                    n_state = ST_CDIV;
                end
            end
            ST_CDIV: begin
                mul_req.start = 1'b1;
                mul_req.sh    = SH_RECIP;
                mul_req.a     = 64'(r_t);
                mul_req.b     = SINE_RECIP[r_k];
                n_state       = ST_CDIV_W;
            end
            ST_CDIV_W: begin
                if (mul_done) begin
                    n_a     = (CF+1)'(ONE_C - mul_res[CF+1:0]);
                    n_state = (r_k == 2'd3) ? ST_SIN : ST_AMUL;
                end
            end
            ST_AMUL: begin
                mul_req.start = 1'b1;
                mul_req.sh    = SH_COLOR;
                mul_req.a     = 64'(r_x2);
                mul_req.b     = 64'(r_a);
                n_state       = ST_AMUL_W;
            end
            ST_AMUL_W: begin
                if (mul_done) begin
                    n_t     = mul_res[CF+1:0];
                    n_k     = r_k + 2'd1;
                    n_state = ST_CDIV;
                end
            end
            ST_SIN: begin
                mul_req.start = 1'b1;
                mul_req.sh    = SH_COLOR;
                mul_req.a     = 64'(r_x);
                mul_req.b     = 64'(r_a);
                n_state       = ST_SIN_W;
            end
            ST_SIN_W: begin
                if (mul_done) begin
                    case (r_phase)
                        2'd0:    n_red = ch;
                        2'd1:    n_grn = ch;
                        default: n_blu = ch;
                    endcase
                    if (r_phase == 2'd2) begin
                        n_state = ST_DONE;
                    end else begin
                        n_phase = r_phase + 2'd1;
                        n_x     = r_q + (XW'({r_phase + 2'd1, 1'b0}) << CF);
                        n_state = ST_RED;
                    end
                end
            end
            ST_DONE: begin
                if (!r_out_valid || i_out_ready) begin
                    n_out_valid = 1'b1;
                    n_out_count = r_count;
                    n_out_argb  = {8'hFF, r_red, r_grn, r_blu};
                    n_state     = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    assign o_out_valid       = r_out_valid;
    assign o_iteration_count = r_out_count;
    assign o_pixel_argb      = r_out_argb;

endmodule
